/* hw/rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Fixed field widths of the channels
  localparam int PAGE_W = 12;
  localparam int ORD_W  = 4;
  localparam int STAT_W = 2;

  // Default pool geometry
  localparam int DEF_NUM_PAGES = 4096;
  localparam int DEF_TOP_ORDER = 10;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_FIND,
    S_A_SCAN,
    S_A_TAKE,
    S_A_SRD,
    S_A_SWR,
    S_F_BRD,
    S_F_BCHK,
    S_F_PWR,
    S_F_FRD,
    S_F_FWR,
    S_RESP
  } bpa_state_t;

endpackage

/* hw/rtl/bpa_if.sv */
// ----------------------------------------------------------------------------
// bpa_in_if / bpa_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface bpa_in_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ORD_W-1:0]  block_order;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, command, block_order, page_number, input ready);
  modport sink   (input valid, command, block_order, page_number, output ready);
endinterface

interface bpa_out_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] result_page;
  logic [STAT_W-1:0] status;

  modport source (output valid, result_page, status, input ready);
  modport sink   (input valid, result_page, status, output ready);
endinterface

/* hw/rtl/buddy_page_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a pool of pages, tags held in one synchronous memory.
// ----------------------------------------------------------------------------
// Reset: clears the counters, then sweeps the tag memory to zero, one page a
//   cycle; no command is taken during the sweep.
// Allocate: a count search up from the requested order, a tag scan from page
//   zero (one read a cycle), then a tag read and a tag write per split level.
// Free: read, check and merge with the buddy per level, then rewrite the final tag.
// One command at a time; the result register lets the next command enter.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int TOP_ORDER = DEF_TOP_ORDER
) (
  input  logic          clk,
  input  logic          rst_n,
  bpa_in_if.sink        in_ch,
  bpa_out_if.source     out_ch
);

  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SW = $clog2(NUM_PAGES + 1);
  localparam int OW = $clog2(TOP_ORDER + 2);
  localparam int IW = $clog2(TOP_ORDER + 1);
  localparam int XA = (AW > PAGE_W) ? AW : PAGE_W;
  localparam int XW = ((XA > TOP_ORDER) ? XA : TOP_ORDER) + 2;

  bpa_state_t        state_r, state_nxt;
  logic [OW-1:0]     o_r, o_nxt;
  logic [OW-1:0]     ord_r, ord_nxt;
  logic [XW-1:0]     p_r, p_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic              chk_r, chk_nxt;
  logic [AW-1:0]     chk_addr_r, chk_addr_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [OW-1:0]     mem_wr_data, mem_rd_data;

  logic [IW-1:0]     cnt_rd_idx;
  logic [SW-1:0]     cnt_rd;
  logic              dec_en, inc_en;
  logic [IW-1:0]     dec_idx, inc_idx;

  logic [XW-1:0]     ord_bit, free_base, bud, split_addr;
  logic [OW-1:0]     tag_cur;

  bpa_tag_mem #(.DEPTH(NUM_PAGES), .AW(AW), .DW(OW)) u_tag_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bpa_free_cnt #(.TOP_ORDER(TOP_ORDER), .IW(IW), .CW(SW)) u_free_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (cnt_rd_idx),
    .rd_cnt  (cnt_rd),
    .dec_en  (dec_en),
    .dec_idx (dec_idx),
    .inc_en  (inc_en),
    .inc_idx (inc_idx)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_page = out_page_r;
  assign out_ch.status      = out_stat_r;

  // Block base of a free request, its buddy and the split target
  assign ord_bit    = XW'(1) << in_ch.block_order;
  assign free_base  = XW'(in_ch.page_number) & ~(ord_bit - XW'(1));
  assign bud        = p_r ^ (XW'(1) << o_r);
  assign split_addr = p_r ^ (XW'(1) << (o_r - OW'(1)));
  assign tag_cur    = o_r + OW'(1);
  assign cnt_rd_idx = o_r[IW-1:0];

  // Sequencer: next state, memory and counter controls
  always_comb begin
    state_nxt     = state_r;
    o_nxt         = o_r;
    ord_nxt       = ord_r;
    p_nxt         = p_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    chk_addr_nxt  = chk_addr_r;
    wa_nxt        = wa_r;
    res_page_nxt  = res_page_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_page_nxt  = out_page_r;
    out_stat_nxt  = out_stat_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = wa_r;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = wa_r;
    dec_en        = 1'b0;
    dec_idx       = o_r[IW-1:0];
    inc_en        = 1'b0;
    inc_idx       = o_r[IW-1:0];

    case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = scan_r[AW-1:0];
        if (scan_r == SW'(NUM_PAGES - 1)) begin
          scan_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          res_page_nxt = '0;
          if (XW'(in_ch.block_order) > XW'(TOP_ORDER)) begin
            res_stat_nxt = ST_RANGE;
            state_nxt    = S_RESP;
          end else begin
            ord_nxt = OW'(in_ch.block_order);
            o_nxt   = OW'(in_ch.block_order);
            if (in_ch.command == CMD_ALLOC) begin
              state_nxt = S_A_FIND;
            end else if (free_base + ord_bit > XW'(NUM_PAGES)) begin
              res_stat_nxt = ST_RANGE;
              state_nxt    = S_RESP;
            end else begin
              p_nxt     = free_base;
              state_nxt = S_F_BRD;
            end
          end
        end
      end

      // Advance to the smallest order with a free block
      S_A_FIND: begin
        if (o_r > OW'(TOP_ORDER)) begin
          res_stat_nxt = ST_NOMEM;
          state_nxt    = S_RESP;
        end else if (cnt_rd == '0) begin
          o_nxt = o_r + OW'(1);
        end else begin
          scan_nxt  = '0;
          chk_nxt   = 1'b0;
          state_nxt = S_A_SCAN;
        end
      end

      // Scan tags from page zero for the lowest head of that order
      S_A_SCAN: begin
        if (chk_r && mem_rd_data == tag_cur) begin
          p_nxt     = XW'(chk_addr_r);
          chk_nxt   = 1'b0;
          state_nxt = S_A_TAKE;
        end else if (scan_r == SW'(NUM_PAGES) && !chk_r) begin
          res_stat_nxt = ST_NOMEM;
          state_nxt    = S_RESP;
        end else if (scan_r < SW'(NUM_PAGES)) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = scan_r[AW-1:0];
          scan_nxt     = scan_r + SW'(1);
          chk_nxt      = 1'b1;
          chk_addr_nxt = scan_r[AW-1:0];
        end else begin
          chk_nxt = 1'b0;
        end
      end

      S_A_TAKE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = p_r[AW-1:0];
        dec_en      = 1'b1;
        state_nxt   = S_A_SRD;
      end

      // Split: read the upper half's tag, then mark it free one order down
      S_A_SRD: begin
        if (o_r == ord_r) begin
          res_stat_nxt = ST_OK;
          res_page_nxt = p_r[PAGE_W-1:0];
          state_nxt    = S_RESP;
        end else begin
          o_nxt       = o_r - OW'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = split_addr[AW-1:0];
          wa_nxt      = split_addr[AW-1:0];
          state_nxt   = S_A_SWR;
        end
      end

      S_A_SWR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = tag_cur;
        dec_en      = (mem_rd_data != '0) && (mem_rd_data <= OW'(TOP_ORDER + 1));
        dec_idx     = IW'(mem_rd_data - OW'(1));
        inc_en      = 1'b1;
        state_nxt   = S_A_SRD;
      end

      // Merge: look at the buddy while below the top order
      S_F_BRD: begin
        if (o_r < OW'(TOP_ORDER) && bud < XW'(NUM_PAGES)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = bud[AW-1:0];
          wa_nxt      = bud[AW-1:0];
          state_nxt   = S_F_BCHK;
        end else begin
          state_nxt = S_F_FRD;
        end
      end

      S_F_BCHK: begin
        if (mem_rd_data == tag_cur) begin
          mem_wr_en   = 1'b1;
          dec_en      = 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = p_r[AW-1:0];
          state_nxt   = S_F_PWR;
        end else begin
          state_nxt = S_F_FRD;
        end
      end

      S_F_PWR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = p_r[AW-1:0];
        dec_en      = (mem_rd_data != '0) && (mem_rd_data <= OW'(TOP_ORDER + 1));
        dec_idx     = IW'(mem_rd_data - OW'(1));
        p_nxt       = p_r & ~(XW'(1) << o_r);
        o_nxt       = o_r + OW'(1);
        state_nxt   = S_F_BRD;
      end

      S_F_FRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = p_r[AW-1:0];
        state_nxt   = S_F_FWR;
      end

      S_F_FWR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = p_r[AW-1:0];
        mem_wr_data  = tag_cur;
        dec_en       = (mem_rd_data != '0) && (mem_rd_data <= OW'(TOP_ORDER + 1));
        dec_idx      = IW'(mem_rd_data - OW'(1));
        inc_en       = 1'b1;
        res_stat_nxt = ST_OK;
        res_page_nxt = '0;
        state_nxt    = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = res_page_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_r      <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    o_r        <= o_nxt;
    ord_r      <= ord_nxt;
    p_r        <= p_nxt;
    chk_addr_r <= chk_addr_nxt;
    wa_r       <= wa_nxt;
    res_page_r <= res_page_nxt;
    res_stat_r <= res_stat_nxt;
    out_page_r <= out_page_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // One command at a time: a transfer closes the input for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a command is in flight");

  // Failed results carry page zero
  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_NOMEM || out_ch.status == ST_RANGE)
      |-> out_ch.result_page == '0)
    else $error("failed result with nonzero page");

  // Status code is always one of the defined results
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_NOMEM ||
                      out_ch.status == ST_RANGE))
    else $error("undefined status code");

endmodule

/* hw/rtl/bpa_tag_mem.sv */
// ----------------------------------------------------------------------------
// bpa_tag_mem
// Page tag store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpa_tag_mem import bpa_pkg::*; #(
  parameter int DEPTH = DEF_NUM_PAGES,
  parameter int AW    = 12,
  parameter int DW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write, and read with the read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/bpa_free_cnt.sv */
// ----------------------------------------------------------------------------
// bpa_free_cnt
// Per-order free block counters with one decrement and one increment a cycle.
// ----------------------------------------------------------------------------
module bpa_free_cnt import bpa_pkg::*; #(
  parameter int TOP_ORDER = DEF_TOP_ORDER,
  parameter int IW        = 4,
  parameter int CW        = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] rd_idx,
  output logic [CW-1:0] rd_cnt,
  input  logic          dec_en,
  input  logic [IW-1:0] dec_idx,
  input  logic          inc_en,
  input  logic [IW-1:0] inc_idx
);

  logic [CW-1:0] cnt_r   [TOP_ORDER+1];
  logic [CW-1:0] cnt_nxt [TOP_ORDER+1];

  assign rd_cnt = cnt_r[rd_idx];

  // Apply the tag rewrite: drop the old order, add the new one
  always_comb begin
    for (int i = 0; i <= TOP_ORDER; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (dec_en && dec_idx == IW'(i) && cnt_r[i] != '0) begin
        cnt_nxt[i] = cnt_nxt[i] - CW'(1);
      end
      if (inc_en && inc_idx == IW'(i)) begin
        cnt_nxt[i] = cnt_nxt[i] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= TOP_ORDER; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule
